// ===== hdl/psqp_pkg.sv =====
package psqp_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int NUM_LEVELS  = 4;
  localparam int LVL_W       = $clog2(NUM_LEVELS);
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDR_W      = $clog2(NUM_LEVELS * QUEUE_DEPTH);
  localparam int MEM_DEPTH   = NUM_LEVELS * QUEUE_DEPTH;
  localparam int TAG_W       = 16;
  localparam int LEN_W       = 10;
  localparam int ENTRY_W     = TAG_W + LEN_W;
  localparam int DT_W        = 16;
  localparam int MPC_W       = 10;
  localparam int PMS_W       = 16;
  localparam int THR_W       = 8;
  localparam int TREM_W      = LEN_W + MPC_W;
  localparam int PEL_W       = 17;
  localparam int CMP_W       = (CNT_W > THR_W) ? CNT_W : THR_W;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_IDX_W   = 2;

  localparam logic [PEL_W-1:0] PAUSE_SAT       = '1;
  localparam logic [MPC_W-1:0] MPC_RESET       = MPC_W'(100);
  localparam logic [PMS_W-1:0] PAUSE_MS_RESET  = PMS_W'(1000);
  localparam logic [THR_W-1:0] THRESH_RESET    = THR_W'(3);

  typedef enum logic [1:0] {
    STAT_QUEUED   = 2'd0,
    STAT_DROPPED  = 2'd1,
    STAT_REJECTED = 2'd2,
    STAT_TICK     = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MS_PER_CHAR = 2'd0,
    CFG_PAUSE_MS    = 2'd1,
    CFG_FLUSH_THR   = 2'd2
  } cfg_idx_t;

  typedef enum logic {
    FUNC_ENQUEUE = 1'b0,
    FUNC_TICK    = 1'b1
  } func_t;

  typedef enum logic {
    S_IDLE,
    S_READ
  } st_t;

endpackage

// ===== hdl/psqp_in_if.sv =====
interface psqp_in_if;
  logic                          valid;
  logic                          ready;
  logic                          func;
  logic [3:0]                    level;
  logic [psqp_pkg::TAG_W-1:0]    msg_tag;
  logic [psqp_pkg::LEN_W-1:0]    msg_length;
  logic [psqp_pkg::DT_W-1:0]     dt_ms;

  modport source (output valid, func, level, msg_tag, msg_length, dt_ms, input ready);
  modport sink (input valid, func, level, msg_tag, msg_length, dt_ms, output ready);
endinterface

// ===== hdl/psqp_out_if.sv =====
interface psqp_out_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    status;
  logic                          start_speech;
  logic [psqp_pkg::TAG_W-1:0]    speech_tag;
  logic [psqp_pkg::LEN_W-1:0]    speech_length;
  logic [2:0]                    speech_level;
  logic                          speaking;
  logic                          in_pause;

  modport source (output valid, status, start_speech, speech_tag, speech_length,
                  speech_level, speaking, in_pause, input ready);
  modport sink (input valid, status, start_speech, speech_tag, speech_length,
                speech_level, speaking, in_pause, output ready);
endinterface

// ===== hdl/psqp_ram.sv =====
module psqp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/priority_speech_queue_pacer_core.sv =====
// Enqueue beats and ticks that start no message: the result is registered straight from the accepted beat.
// Tick that starts a message: the queue memory read is registered first, then the S_READ state registers the result.
// Acceptance: a new beat is taken in S_IDLE while the result side keeps up; none is taken in S_READ.
// Reset (rst_n, synchronous): empties all queues, clears the pacing flags and timers and
// loads the register defaults; the queue memory itself is not cleared.
module priority_speech_queue_pacer_core (
  input  logic                              clk,
  input  logic                              rst_n,
  psqp_in_if.sink                           in_ch,
  psqp_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [psqp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [psqp_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int IW = psqp_pkg::IDX_W;
  localparam int CW = psqp_pkg::CNT_W;
  localparam int LW = psqp_pkg::LVL_W;

  psqp_pkg::st_t st_r, st_nxt;

  logic [IW-1:0] head_r [psqp_pkg::NUM_LEVELS];
  logic [IW-1:0] head_nxt [psqp_pkg::NUM_LEVELS];
  logic [CW-1:0] cnt_r [psqp_pkg::NUM_LEVELS];
  logic [CW-1:0] cnt_nxt [psqp_pkg::NUM_LEVELS];

  logic pend_r, pend_nxt;
  logic speak_r, speak_nxt;
  logic pause_r, pause_nxt;
  logic [psqp_pkg::TREM_W-1:0] trem_r, trem_nxt;
  logic [psqp_pkg::PEL_W-1:0]  pel_r, pel_nxt;

  logic [psqp_pkg::MPC_W-1:0] mpc_r;
  logic [psqp_pkg::PMS_W-1:0] pms_r;
  logic [psqp_pkg::THR_W-1:0] thr_r;

  logic [2:0] sel_lvl_r, sel_lvl_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic [1:0]                  status_r, status_nxt;
  logic                        start_r, start_nxt;
  logic [psqp_pkg::TAG_W-1:0]  tag_r, tag_nxt;
  logic [psqp_pkg::LEN_W-1:0]  len_r, len_nxt;
  logic [2:0]                  lvl_r, lvl_nxt;
  logic                        ospk_r, ospk_nxt;
  logic                        opause_r, opause_nxt;

  logic                             mem_we;
  logic [psqp_pkg::ADDR_W-1:0]      mem_waddr;
  logic [psqp_pkg::ENTRY_W-1:0]     mem_wdata;
  logic [psqp_pkg::ADDR_W-1:0]      mem_raddr;
  logic [psqp_pkg::ENTRY_W-1:0]     mem_rdata;

  logic acc;
  logic cnt_ok;

  function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] a, input logic [CW-1:0] b);
    logic [CW:0] s;
    s = (CW+1)'(a) + (CW+1)'(b);
    if (s >= (CW+1)'(psqp_pkg::QUEUE_DEPTH)) begin
      s = s - (CW+1)'(psqp_pkg::QUEUE_DEPTH);
    end
    return s[IW-1:0];
  endfunction

  function automatic logic [psqp_pkg::ADDR_W-1:0] slot_addr(input logic [LW-1:0] q,
                                                            input logic [IW-1:0] idx);
    return psqp_pkg::ADDR_W'(q) * psqp_pkg::ADDR_W'(psqp_pkg::QUEUE_DEPTH)
         + psqp_pkg::ADDR_W'(idx);
  endfunction

  psqp_ram #(
    .WIDTH (psqp_pkg::ENTRY_W),
    .DEPTH (psqp_pkg::MEM_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign in_ch.ready = (st_r == psqp_pkg::S_IDLE) && (!out_valid_r || out_ch.ready);
  assign acc = in_ch.valid && in_ch.ready;

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = status_r;
  assign out_ch.start_speech  = start_r;
  assign out_ch.speech_tag    = tag_r;
  assign out_ch.speech_length = len_r;
  assign out_ch.speech_level  = lvl_r;
  assign out_ch.speaking      = ospk_r;
  assign out_ch.in_pause      = opause_r;

  always_comb begin
    logic [LW-1:0]              q;
    logic [IW-1:0]              qhead;
    logic [CW-1:0]              qcnt;
    logic                       lvl_ok;
    logic [psqp_pkg::PEL_W:0]   psum;
    logic                       found;
    logic [LW-1:0]              sq;
    logic [CW-1:0]              left;

    st_nxt        = st_r;
    head_nxt      = head_r;
    cnt_nxt       = cnt_r;
    pend_nxt      = pend_r;
    speak_nxt     = speak_r;
    pause_nxt     = pause_r;
    trem_nxt      = trem_r;
    pel_nxt       = pel_r;
    sel_lvl_nxt   = sel_lvl_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    status_nxt    = status_r;
    start_nxt     = start_r;
    tag_nxt       = tag_r;
    len_nxt       = len_r;
    lvl_nxt       = lvl_r;
    ospk_nxt      = ospk_r;
    opause_nxt    = opause_r;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = {in_ch.msg_tag, in_ch.msg_length};
    mem_raddr     = '0;

    q      = LW'(in_ch.level - 4'd1);
    qhead  = head_r[q];
    qcnt   = cnt_r[q];
    lvl_ok = (in_ch.level >= 4'd1) && (in_ch.level <= 4'(psqp_pkg::NUM_LEVELS));
    psum   = '0;
    found  = 1'b0;
    sq     = '0;
    left   = '0;

    unique case (st_r)
      psqp_pkg::S_IDLE: begin
        if (acc) begin
          start_nxt = 1'b0;
          tag_nxt   = '0;
          len_nxt   = '0;
          lvl_nxt   = '0;
          if (in_ch.func == psqp_pkg::FUNC_ENQUEUE) begin
            out_valid_nxt = 1'b1;
            ospk_nxt      = speak_r;
            opause_nxt    = pause_r;
            if (!lvl_ok) begin
              status_nxt = psqp_pkg::STAT_REJECTED;
            end else if (qcnt >= CW'(psqp_pkg::QUEUE_DEPTH)) begin
              status_nxt  = psqp_pkg::STAT_DROPPED;
              mem_we      = 1'b1;
              mem_waddr   = slot_addr(q, qhead);
              head_nxt[q] = wrap_add(qhead, CW'(1));
            end else begin
              status_nxt = psqp_pkg::STAT_QUEUED;
              mem_we     = 1'b1;
              mem_waddr  = slot_addr(q, wrap_add(qhead, qcnt));
              cnt_nxt[q] = qcnt + CW'(1);
            end
          end else begin
            status_nxt = psqp_pkg::STAT_TICK;
            if (pause_r) begin
              psum    = (psqp_pkg::PEL_W+1)'(pel_r) + (psqp_pkg::PEL_W+1)'(in_ch.dt_ms);
              pel_nxt = (psum > (psqp_pkg::PEL_W+1)'(psqp_pkg::PAUSE_SAT)) ?
                        psqp_pkg::PAUSE_SAT : psum[psqp_pkg::PEL_W-1:0];
              if (pel_nxt > psqp_pkg::PEL_W'(pms_r)) begin
                pause_nxt = 1'b0;
              end
            end
            if (pend_r) begin
              speak_nxt = 1'b1;
              pend_nxt  = 1'b0;
            end
            if (speak_nxt) begin
              if (psqp_pkg::TREM_W'(in_ch.dt_ms) > trem_r) begin
                trem_nxt  = '0;
                speak_nxt = 1'b0;
                pause_nxt = 1'b1;
                pel_nxt   = '0;
              end else begin
                trem_nxt = trem_r - psqp_pkg::TREM_W'(in_ch.dt_ms);
              end
            end else if (!pause_nxt) begin
              for (int i = 0; i < psqp_pkg::NUM_LEVELS; i++) begin
                if (!found && cnt_r[psqp_pkg::NUM_LEVELS-1-i] != '0) begin
                  found = 1'b1;
                  sq    = LW'(psqp_pkg::NUM_LEVELS - 1 - i);
                end
              end
              if (found) begin
                mem_raddr    = slot_addr(sq, head_r[sq]);
                head_nxt[sq] = wrap_add(head_r[sq], CW'(1));
                left         = cnt_r[sq] - CW'(1);
                cnt_nxt[sq]  = left;
                if (sq == '0 && psqp_pkg::CMP_W'(left) > psqp_pkg::CMP_W'(thr_r)) begin
                  cnt_nxt[0]  = '0;
                  head_nxt[0] = '0;
                end
                pend_nxt    = 1'b1;
                sel_lvl_nxt = 3'(sq) + 3'd1;
                st_nxt      = psqp_pkg::S_READ;
              end
            end
            if (!found) begin
              out_valid_nxt = 1'b1;
              ospk_nxt      = speak_nxt;
              opause_nxt    = pause_nxt;
            end
          end
        end
      end
      psqp_pkg::S_READ: begin
        trem_nxt      = psqp_pkg::TREM_W'(mem_rdata[psqp_pkg::LEN_W-1:0])
                      * psqp_pkg::TREM_W'(mpc_r);
        out_valid_nxt = 1'b1;
        status_nxt    = psqp_pkg::STAT_TICK;
        start_nxt     = 1'b1;
        tag_nxt       = mem_rdata[psqp_pkg::ENTRY_W-1:psqp_pkg::LEN_W];
        len_nxt       = mem_rdata[psqp_pkg::LEN_W-1:0];
        lvl_nxt       = sel_lvl_r;
        ospk_nxt      = speak_r;
        opause_nxt    = pause_r;
        st_nxt        = psqp_pkg::S_IDLE;
      end
      default: st_nxt = psqp_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= psqp_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
      speak_r     <= 1'b0;
      pause_r     <= 1'b0;
      trem_r      <= '0;
      pel_r       <= '0;
      sel_lvl_r   <= '0;
      for (int i = 0; i < psqp_pkg::NUM_LEVELS; i++) begin
        head_r[i] <= '0;
        cnt_r[i]  <= '0;
      end
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
      speak_r     <= speak_nxt;
      pause_r     <= pause_nxt;
      trem_r      <= trem_nxt;
      pel_r       <= pel_nxt;
      sel_lvl_r   <= sel_lvl_nxt;
      head_r      <= head_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    start_r  <= start_nxt;
    tag_r    <= tag_nxt;
    len_r    <= len_nxt;
    lvl_r    <= lvl_nxt;
    ospk_r   <= ospk_nxt;
    opause_r <= opause_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mpc_r <= psqp_pkg::MPC_RESET;
      pms_r <= psqp_pkg::PAUSE_MS_RESET;
      thr_r <= psqp_pkg::THRESH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        psqp_pkg::CFG_MS_PER_CHAR: mpc_r <= cfg_wdata[psqp_pkg::MPC_W-1:0];
        psqp_pkg::CFG_PAUSE_MS:    pms_r <= cfg_wdata[psqp_pkg::PMS_W-1:0];
        psqp_pkg::CFG_FLUSH_THR:   thr_r <= cfg_wdata[psqp_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cnt_ok = 1'b1;
    for (int i = 0; i < psqp_pkg::NUM_LEVELS; i++) begin
      if (cnt_r[i] > CW'(psqp_pkg::QUEUE_DEPTH)) begin
        cnt_ok = 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_read_after_tick: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == psqp_pkg::S_READ |-> $past(acc && in_ch.func == psqp_pkg::FUNC_TICK))
    else $error("queue read without a tick beat");

  a_read_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == psqp_pkg::S_READ |=> out_valid_r && start_r && st_r == psqp_pkg::S_IDLE)
    else $error("selected message not presented after read");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n) cnt_ok)
    else $error("queue count beyond depth");

  a_speak_pause_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(speak_r && pause_r) && !(pend_r && pause_r))
    else $error("speaking and pause overlap");
`endif

endmodule
